FILE: hdl/rvalu_pkg.sv
// Package with operation codes, controller state and command/status types for the ALU.
`default_nettype none
package rvalu_pkg;
  localparam int unsigned XlenDefault = 64;
  localparam int unsigned RegCountDefault = 32;
  localparam int unsigned CmdWidth = 4;
  localparam int unsigned IdxWidth = 5;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_XOR   = 4'd2,
    OP_OR    = 4'd3,
    OP_AND   = 4'd4,
    OP_MUL   = 4'd5,
    OP_MULH  = 4'd6,
    OP_MULHU = 4'd7,
    OP_REMUW = 4'd8,
    OP_LOAD  = 4'd9
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_ITER  = 5'b00100,
    ST_FIX   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the request
    logic read;     // register file read data is valid, load operands
    logic step;     // one iteration of the multiply or divide unit
    logic finish;   // form the result and write back
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic iterative;  // the latched operation uses the shift unit
    logic last;       // the current iteration is the final one
  } dp_stat_t;
endpackage
`default_nettype wire

FILE: hdl/rvalu_datapath.sv
// Datapath: register file, operand registers and the shared shift-add/subtract unit.
`default_nettype none
module rvalu_datapath #(
  parameter int unsigned Xlen = rvalu_pkg::XlenDefault,
  parameter int unsigned RegCount = rvalu_pkg::RegCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rvalu_pkg::dp_cmd_t            cmd_i,
  output rvalu_pkg::dp_stat_t                stat_o,
  input  wire logic [rvalu_pkg::CmdWidth-1:0] op_i,
  input  wire logic [rvalu_pkg::IdxWidth-1:0] src1_index_i,
  input  wire logic [rvalu_pkg::IdxWidth-1:0] src2_index_i,
  input  wire logic [rvalu_pkg::IdxWidth-1:0] dest_index_i,
  input  wire logic [Xlen-1:0]               load_value_i,
  output logic [Xlen-1:0]                    result_value_o,
  output logic                               status_o
);
  import rvalu_pkg::*;

  localparam int unsigned CntWidth = $clog2(Xlen);
  localparam int unsigned Half = Xlen / 2;
  localparam logic [IdxWidth:0] RegLimit = (IdxWidth + 1)'(RegCount);

  logic [Xlen-1:0] rf_q [RegCount];
  logic [RegCount-1:0] vld_q;
  logic [Xlen-1:0] rd1_q, rd2_q;

  logic [CmdWidth-1:0] op_q;
  logic [IdxWidth-1:0] s1_q, s2_q, dst_q;
  logic [Xlen-1:0] ld_q;

  logic [Xlen-1:0] a_q, b_q;      // multiplicand / divisor
  logic [Xlen-1:0] hi_q, lo_q;    // product high/low or remainder/quotient
  logic [CntWidth-1:0] cnt_q;
  logic [Xlen-1:0] res_q;
  logic status_q;

  logic is_div, is_mul;
  logic [Xlen:0] add_sum;
  logic [Half:0] div_trial;
  logic [Half-1:0] div_rem;
  logic [Xlen-1:0] fin;
  logic ok;
  logic [Xlen-1:0] op1, op2;

  assign is_mul = (op_q == OP_MUL) || (op_q == OP_MULH) || (op_q == OP_MULHU);
  assign is_div = (op_q == OP_REMUW);
  assign stat_o.iterative = is_mul || is_div;
  assign stat_o.last = is_div ? (cnt_q == CntWidth'(Half - 1))
                              : (cnt_q == CntWidth'(Xlen - 1));

  // Source read: entry zero, out-of-range and never-written entries read zero.
  always_ff @(posedge clk_i) begin
    rd1_q <= ({1'b0, s1_q} < RegLimit && vld_q[s1_q[$clog2(RegCount)-1:0]])
             ? rf_q[s1_q[$clog2(RegCount)-1:0]] : '0;
    rd2_q <= ({1'b0, s2_q} < RegLimit && vld_q[s2_q[$clog2(RegCount)-1:0]])
             ? rf_q[s2_q[$clog2(RegCount)-1:0]] : '0;
  end

  // Unsigned shift-add multiply: one multiplier bit per step.
  assign add_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
  // Restoring divide on the low half: remainder in hi_q, dividend bits in lo_q.
  assign div_trial = {hi_q[Half-1:0], lo_q[Half-1]} - {1'b0, b_q[Half-1:0]};
  assign div_rem = div_trial[Half] ? {hi_q[Half-2:0], lo_q[Half-1]} : div_trial[Half-1:0];

  assign op1 = rd1_q;
  assign op2 = rd2_q;

  always_comb begin
    ok = 1'b1;
    fin = '0;
    unique case (op_q)
      OP_ADD:   fin = op1 + op2;
      OP_SUB:   fin = op1 - op2;
      OP_XOR:   fin = op1 ^ op2;
      OP_OR:    fin = op1 | op2;
      OP_AND:   fin = op1 & op2;
      OP_MUL:   fin = lo_q;
      OP_MULH:  fin = hi_q - (op1[Xlen-1] ? op2 : '0) - (op2[Xlen-1] ? op1 : '0);
      OP_MULHU: fin = hi_q;
      OP_REMUW: begin
        if (op2[Half-1:0] == '0) begin
          fin = {{Half{op1[Half-1]}}, op1[Half-1:0]};
        end else begin
          fin = {{Half{hi_q[Half-1]}}, hi_q[Half-1:0]};
        end
      end
      OP_LOAD:  fin = ld_q;
      default:  ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= op_i;
      s1_q <= src1_index_i;
      s2_q <= src2_index_i;
      dst_q <= dest_index_i;
      ld_q <= load_value_i;
    end
    if (cmd_i.read) begin
      a_q <= rd1_q;
      b_q <= rd2_q;
      hi_q <= '0;
      lo_q <= is_div ? {{Half{1'b0}}, rd1_q[Half-1:0]} : rd2_q;
    end else if (cmd_i.step) begin
      if (is_div) begin
        hi_q <= {{Half{1'b0}}, div_rem};
        lo_q <= {lo_q[Xlen-2:0], 1'b0};
      end else begin
        hi_q <= add_sum[Xlen:1];
        lo_q <= {add_sum[0], lo_q[Xlen-1:1]};
      end
    end
    if (cmd_i.finish) begin
      res_q <= ok ? fin : '0;
      status_q <= ~ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.read) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Register file write; valid bits stand in for the reset clear.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && ok && dst_q != '0 && {1'b0, dst_q} < RegLimit) begin
      rf_q[dst_q[$clog2(RegCount)-1:0]] <= fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.finish && ok && dst_q != '0 && {1'b0, dst_q} < RegLimit) begin
      vld_q[dst_q[$clog2(RegCount)-1:0]] <= 1'b1;
    end
  end

  assign result_value_o = res_q;
  assign status_o = status_q;
endmodule
`default_nettype wire

FILE: hdl/rvalu_ctrl.sv
// Controller state machine that sequences capture, read, iteration and result.
`default_nettype none
module rvalu_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rvalu_pkg::dp_cmd_t        cmd_o,
  input  wire rvalu_pkg::dp_stat_t  stat_i
);
  import rvalu_pkg::*;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // Register file data for the latched sources lands at this edge.
        state_d = ST_ITER;
      end
      ST_ITER: begin
        cmd_o.read = 1'b1;
        state_d = stat_i.iterative ? ST_FIX : ST_OUT;
        if (!stat_i.iterative) begin
          cmd_o.finish = 1'b1;
        end
      end
      ST_FIX: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/rvalu_seq.sv
// Result stage: runs the finishing cycle after the iterative unit and holds the output.
`default_nettype none
module rvalu_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rvalu_pkg::dp_cmd_t       cmd_o,
  input  wire rvalu_pkg::dp_stat_t stat_i
);
  import rvalu_pkg::*;

  // Tracks whether an iterative request has finished its steps and needs its finish pass.
  logic pend_q;
  rvalu_pkg::dp_cmd_t ctrl_cmd;
  logic ctrl_out_valid;
  logic ctrl_out_ready;

  // The result is held back from the output during the finish pass.
  assign ctrl_out_ready = out_ready_i && !pend_q;

  rvalu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (ctrl_out_valid),
    .out_ready_i (ctrl_out_ready),
    .cmd_o       (ctrl_cmd),
    .stat_i      (stat_i)
  );

  always_comb begin
    cmd_o = ctrl_cmd;
    // The cycle after the last step forms the result and writes it back.
    if (pend_q) begin
      cmd_o.finish = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= ctrl_cmd.step && stat_i.last;
    end
  end

  assign out_valid_o = ctrl_out_valid && !pend_q;
endmodule
`default_nettype wire

FILE: hdl/rv64_register_register_alu.sv
// Top level of the RV64 register-register ALU with its 32 x 64-bit register file.
`default_nettype none
// Channel   Signals                                                   Direction
// request   in_valid_i, in_ready_o, cmd_i, src1_index_i, src2_index_i,
//           dest_index_i, load_value_i                                in
// result    out_valid_o, out_ready_i, result_value_o, status_o        out
//
// One request is worked at a time. Simple operations and load read the
// register file, then operate and write back, and the result then shows valid;
// mul, mulh and mulhu iterate on the shared one-bit-per-cycle shift unit over
// all multiplier bits and remuw over the low half, then take one finish pass.
// After the result is taken the block is ready for a new request in the next cycle.
// Reset clears the controller and the register file valid bits, so every
// register reads zero after reset. A stalled result holds until taken; no new
// request is accepted until then.
module rv64_register_register_alu #(
  parameter int unsigned XLEN = rvalu_pkg::XlenDefault,
  parameter int unsigned REG_COUNT = rvalu_pkg::RegCountDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [rvalu_pkg::CmdWidth-1:0] cmd_i,
  input  wire logic [rvalu_pkg::IdxWidth-1:0] src1_index_i,
  input  wire logic [rvalu_pkg::IdxWidth-1:0] src2_index_i,
  input  wire logic [rvalu_pkg::IdxWidth-1:0] dest_index_i,
  input  wire logic [XLEN-1:0]                load_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [XLEN-1:0]                     result_value_o,
  output logic                                status_o
);
  import rvalu_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencing: the controller plus the finish-pass tracking.
  rvalu_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // Register file, operand registers and the iterative multiply/divide unit.
  rvalu_datapath #(
    .Xlen     (XLEN),
    .RegCount (REG_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .op_i           (cmd_i),
    .src1_index_i   (src1_index_i),
    .src2_index_i   (src2_index_i),
    .dest_index_i   (dest_index_i),
    .load_value_i   (load_value_i),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );
endmodule
`default_nettype wire
